[sv/mcct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcct_pkg: shared types and codes for the countdown timer bank
// Command codes, the stored timer entry and the dispatch limit.
// ----------------------------------------------------------------------------
package mcct_pkg;

	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned FIRE_CNT_W  = 4;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_TICK     = 3'd0;
	localparam mode_t MODE_DISPATCH = 3'd1;
	localparam mode_t MODE_START    = 3'd2;
	localparam mode_t MODE_STOP     = 3'd3;
	localparam mode_t MODE_RUN      = 3'd4;
	localparam mode_t MODE_RELOAD   = 3'd5;
	localparam mode_t MODE_READ     = 3'd6;
	localparam mode_t MODE_NONE     = 3'd7;

	typedef struct packed {
		logic [31:0] count;
		logic        running;
		logic        expired;
		logic        base_sel;
	} timer_entry_t;

endpackage
`default_nettype wire

[sv/mcct_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcct_ifs: command and response channels of the timer bank
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mcct_in_if;
	import mcct_pkg::*;

	logic        valid;
	logic        ready;
	mode_t       mode;
	logic [2:0]  timer_index;
	logic [31:0] count_value;
	logic        time_base;
	logic        run_state;
	logic        tenth_tick;
	logic        second_tick;

	modport source (
		output valid, mode, timer_index, count_value, time_base, run_state,
		       tenth_tick, second_tick,
		input  ready
	);

	modport sink (
		input  valid, mode, timer_index, count_value, time_base, run_state,
		       tenth_tick, second_tick,
		output ready
	);
endinterface

interface mcct_out_if;
	logic        valid;
	logic        ready;
	logic        fired_valid;
	logic [2:0]  fired_timer;
	logic [31:0] count_read;
	logic        last;

	modport source (
		output valid, fired_valid, fired_timer, count_read, last,
		input  ready
	);

	modport sink (
		input  valid, fired_valid, fired_timer, count_read, last,
		output ready
	);
endinterface
`default_nettype wire

[sv/mcct_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcct_ram: timer entry store
// One write and one read port, registered read. Entries never written read
// as zero through a per-entry valid bit cleared at reset.
// ----------------------------------------------------------------------------
module mcct_ram #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output mcct_pkg::timer_entry_t rdata,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  mcct_pkg::timer_entry_t wdata
);
	import mcct_pkg::*;

	timer_entry_t     mem [DEPTH];
	timer_entry_t     rdata_s1;
	logic [DEPTH-1:0] vld_q;
	logic             rvld_s1;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (re)
				rvld_s1 <= vld_q[raddr];
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : '0;

endmodule
`default_nettype wire

[sv/multi_channel_countdown_timers_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_countdown_timers_unit: bank of countdown timers
// Timer state held in a registered-read RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word: tick, dispatch, start, stop, run state,
//   reload or read. rsp returns one or more words per command; last marks
//   the final one. Dispatch gives one word per expired running timer
//   (ascending, at most eight), or a single empty word if none.
//   Tick and dispatch walk every entry through the RAM read/modify/write
//   pipe; single-timer commands visit one entry, and an unused mode or an
//   out-of-range index visits none. The walk is set by the one read and one
//   write port of the entry RAM.
//   The last response word sits in an output register, so the next command
//   is taken while it waits. A stalled receiver holds the walk only when a
//   dispatch needs to hand over a further word.
//   Reset clears all timers (stopped, zero count) at once; commands are
//   accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
module multi_channel_countdown_timers_unit #(
	parameter int unsigned TIMER_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	mcct_in_if.sink    cmd,
	mcct_out_if.source rsp
);
	import mcct_pkg::*;

	localparam int unsigned IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_COUNT - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

	state_t                state_q;
	mode_t                 mode_q;
	logic [31:0]           cval_q;
	logic                  tb_q;
	logic                  rs_q;
	logic                  tenth_q;
	logic                  sec_q;
	logic [31:0]           rd_q;
	logic [IW-1:0]         raddr_q;
	logic [IW-1:0]         end_q;
	logic                  issued_q;
	logic                  vld_s1;
	logic [IW-1:0]         idx_s1;
	logic [FIRE_CNT_W-1:0] fire_n_q;
	logic                  pend_vld_q;
	logic [2:0]            pend_idx_q;
	logic                  out_vld_q;
	logic                  out_fv_q;
	logic [2:0]            out_ft_q;
	logic [31:0]           out_cnt_q;
	logic                  out_last_q;

	logic [6:0]    cmd_idx_ext;
	logic          cmd_ok;
	logic [IW-1:0] cmd_addr;
	timer_entry_t  cur;
	timer_entry_t  nxt;
	logic          fire;
	logic          slot_free;
	logic          stall;
	logic          walk_go;
	logic          ram_re;
	logic          ram_we;
	logic          out_load;

	assign cmd_idx_ext = 7'(cmd.timer_index);
	assign cmd_ok      = cmd_idx_ext < 7'(TIMER_COUNT);
	assign cmd_addr    = cmd_idx_ext[IW-1:0];

	mcct_ram #(
		.DEPTH (TIMER_COUNT),
		.AW    (IW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (ram_re),
		.raddr  (raddr_q),
		.rdata  (cur),
		.we     (ram_we),
		.waddr  (idx_s1),
		.wdata  (nxt)
	);

	always_comb begin
		nxt  = cur;
		fire = 1'b0;
		unique case (mode_q)
			MODE_TICK: begin
				if (cur.running) begin
					if (cur.count != '0) begin
						if (cur.base_sel ? sec_q : tenth_q)
							nxt.count = cur.count - 32'd1;
					end else begin
						nxt.expired = 1'b1;
					end
				end
			end
			MODE_DISPATCH: begin
				if (cur.running && cur.expired &&
				    fire_n_q < FIRE_CNT_W'(MAX_RESULTS)) begin
					nxt.running = 1'b0;
					nxt.expired = 1'b0;
					fire        = 1'b1;
				end
			end
			MODE_START: begin
				nxt.count    = cval_q;
				nxt.running  = 1'b1;
				nxt.expired  = 1'b0;
				nxt.base_sel = tb_q;
			end
			MODE_STOP: begin
				nxt.count   = '0;
				nxt.running = 1'b0;
				nxt.expired = 1'b0;
			end
			MODE_RUN: nxt.running = rs_q;
			MODE_RELOAD: begin
				if (cur.running)
					nxt.count = cval_q;
			end
			default: ;
		endcase
	end

	assign slot_free = !out_vld_q || rsp.ready;
	assign stall     = vld_s1 && fire && pend_vld_q && !slot_free;
	assign walk_go   = (state_q == ST_WALK) && !stall;
	assign ram_re    = walk_go && !issued_q;
	assign ram_we    = walk_go && vld_s1;
	assign out_load  = (walk_go && vld_s1 && fire && pend_vld_q) ||
	                   ((state_q == ST_DONE) && slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_TICK;
			cval_q     <= '0;
			tb_q       <= 1'b0;
			rs_q       <= 1'b0;
			tenth_q    <= 1'b0;
			sec_q      <= 1'b0;
			rd_q       <= '0;
			raddr_q    <= '0;
			end_q      <= '0;
			issued_q   <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			fire_n_q   <= '0;
			pend_vld_q <= 1'b0;
			pend_idx_q <= '0;
			out_vld_q  <= 1'b0;
			out_fv_q   <= 1'b0;
			out_ft_q   <= '0;
			out_cnt_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_load)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						mode_q     <= cmd.mode;
						cval_q     <= cmd.count_value;
						tb_q       <= cmd.time_base;
						rs_q       <= cmd.run_state;
						tenth_q    <= cmd.tenth_tick;
						sec_q      <= cmd.second_tick;
						rd_q       <= '0;
						fire_n_q   <= '0;
						pend_vld_q <= 1'b0;
						issued_q   <= 1'b0;
						vld_s1     <= 1'b0;
						if (cmd.mode == MODE_TICK || cmd.mode == MODE_DISPATCH) begin
							raddr_q <= '0;
							end_q   <= LAST_IDX;
							state_q <= ST_WALK;
						end else if (cmd_ok && cmd.mode != MODE_NONE) begin
							raddr_q <= cmd_addr;
							end_q   <= cmd_addr;
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (!stall) begin
						if (vld_s1) begin
							if (mode_q == MODE_READ)
								rd_q <= cur.count;
							if (fire) begin
								fire_n_q   <= fire_n_q + 1'b1;
								pend_vld_q <= 1'b1;
								pend_idx_q <= 3'(idx_s1);
								// previous hit is not the final word
								if (pend_vld_q) begin
									out_fv_q   <= 1'b1;
									out_ft_q   <= pend_idx_q;
									out_cnt_q  <= '0;
									out_last_q <= 1'b0;
								end
							end
						end
						if (!issued_q) begin
							vld_s1 <= 1'b1;
							idx_s1 <= raddr_q;
							if (raddr_q == end_q)
								issued_q <= 1'b1;
							else
								raddr_q <= raddr_q + 1'b1;
						end else begin
							vld_s1  <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_fv_q   <= pend_vld_q;
						out_ft_q   <= pend_vld_q ? pend_idx_q : 3'd0;
						out_cnt_q  <= rd_q;
						out_last_q <= 1'b1;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_vld_q;
	assign rsp.fired_valid = out_fv_q;
	assign rsp.fired_timer = out_ft_q;
	assign rsp.count_read  = out_cnt_q;
	assign rsp.last        = out_last_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q != ST_IDLE))
		else $error("command taken but sequencer stayed idle");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_n_q <= FIRE_CNT_W'(MAX_RESULTS))
		else $error("dispatch count beyond limit");

	a_stall_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (!ram_we && !ram_re))
		else $error("RAM accessed during stall");

	a_open_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_last_q) |-> pend_vld_q)
		else $error("non-final word without a held dispatch");

	a_pend_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (mode_q == MODE_DISPATCH))
		else $error("held dispatch outside dispatch command");

endmodule
`default_nettype wire
